// ===== src/motor_position_pid_loop_core_defines.svh =====
// Assertion macros shared by the motor position PID loop RTL.
`ifndef MOTOR_POSITION_PID_LOOP_CORE_DEFINES_SVH
`define MOTOR_POSITION_PID_LOOP_CORE_DEFINES_SVH
`ifndef SYNTHESIS
// Same-cycle implication, sampled on clk, off during reset.
`define MPPL_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
// Next-cycle implication, sampled on clk, off during reset.
`define MPPL_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define MPPL_ASSERT_IMP(lbl, ante, cons, msg)
`define MPPL_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

// ===== src/mppl_pkg.sv =====
// Types and constants shared by the motor position PID loop modules.
package mppl_pkg;
	localparam int DVD_W   = 21;
	localparam int DSR_W   = 13;
	localparam int RAW_W   = 12;
	localparam int ANGLE_W = 9;
	localparam int TURN_W  = 12;
	localparam int SHAFT_W = 20;
	localparam int ERR_W   = 21;
	localparam int COEF_W  = 24;
	localparam int PROD_W  = COEF_W + ERR_W;
	localparam int ACC_W   = 48;
	localparam int DRV_W   = 32;
	localparam int MAG_W   = 16;
	localparam int ADDR_W  = 4;

	localparam logic [1:0] REG_COEF_NOW   = 2'd0;
	localparam logic [1:0] REG_COEF_PREV  = 2'd1;
	localparam logic [1:0] REG_COEF_PREV2 = 2'd2;

	typedef enum logic [1:0] {
		MUL_NOW   = 2'd0,
		MUL_PREV  = 2'd1,
		MUL_PREV2 = 2'd2
	} mul_sel_t;

	typedef struct packed {
		logic     load_in;
		logic     div_go;
		logic     cap_enc;
		logic     turn_upd;
		logic     cap_pot;
		logic     cap_avg;
		logic     mul_go;
		mul_sel_t mul_sel;
		logic     acc_init;
		logic     acc_add;
		logic     finish;
	} cmd_t;

	typedef struct packed {
		logic div_busy;
		logic div_done;
		logic out_free;
	} sts_t;
endpackage

// ===== src/mppl_div.sv =====
// Radix-2 restoring divider, one quotient bit per cycle.
module mppl_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        go,
	input  logic [mppl_pkg::DVD_W-1:0] dividend,
	input  logic [mppl_pkg::DSR_W-1:0] divisor,
	output logic [mppl_pkg::DVD_W-1:0] quotient,
	output logic                        busy,
	output logic                        done
);
	import mppl_pkg::*;

	localparam int CNT_W = $clog2(DVD_W);

	logic [DVD_W-1:0] quo_q;
	logic [DSR_W-1:0] rem_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [DSR_W:0]   rem_sh;
	logic [DSR_W+1:0] diff;

	assign rem_sh = {rem_q, quo_q[DVD_W-1]};
	assign diff   = {1'b0, rem_sh} - {2'b00, divisor};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == '0);
			if (go) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(DVD_W - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
				end
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			quo_q <= dividend;
			rem_q <= '0;
		end else if (busy_q) begin
			if (!diff[DSR_W+1]) begin
				rem_q <= diff[DSR_W-1:0];
				quo_q <= {quo_q[DVD_W-2:0], 1'b1};
			end else begin
				rem_q <= rem_sh[DSR_W-1:0];
				quo_q <= {quo_q[DVD_W-2:0], 1'b0};
			end
		end
	end

	assign quotient = quo_q;
	assign busy     = busy_q;
	assign done     = done_q;
endmodule

// ===== src/mppl_datapath.sv =====
// Datapath: angle scaling, unwrap, moving average, shared multiply and drive accumulator.
module mppl_datapath #(
	parameter int WINDOW_LEN          = 20,
	parameter int ENCODER_FULL_SCALE  = 4088,
	parameter int SETPOINT_FULL_SCALE = 4096,
	parameter int TURN_LIMIT          = 2047
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  mppl_pkg::cmd_t                      cmd,
	output mppl_pkg::sts_t                      sts,
	input  logic [mppl_pkg::RAW_W-1:0]          encoder_sample,
	input  logic [mppl_pkg::RAW_W-1:0]          setpoint_sample,
	input  logic signed [mppl_pkg::COEF_W-1:0]  coef_error_now,
	input  logic signed [mppl_pkg::COEF_W-1:0]  coef_error_prev,
	input  logic signed [mppl_pkg::COEF_W-1:0]  coef_error_prev2,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [mppl_pkg::MAG_W-1:0]          drive_magnitude,
	output logic                                drive_forward,
	output logic [mppl_pkg::SHAFT_W-1:0]        shaft_angle,
	output logic [mppl_pkg::ANGLE_W-1:0]        setpoint_angle
);
	import mppl_pkg::*;

	localparam int IDX_W  = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
	localparam int FILL_W = $clog2(WINDOW_LEN + 1);
	localparam int SUM_W  = ANGLE_W + FILL_W;
	localparam logic [ANGLE_W-1:0] ANGLE_MAX = '1;
	localparam logic signed [TURN_W-1:0] TURN_HI = TURN_W'(TURN_LIMIT);
	localparam logic signed [TURN_W-1:0] TURN_LO = -TURN_W'(TURN_LIMIT);
	localparam logic signed [DRV_W-1:0] DRV_MAX = {1'b0, {(DRV_W-1){1'b1}}};
	localparam logic signed [DRV_W-1:0] DRV_MIN = {1'b1, {(DRV_W-1){1'b0}}};

	// degrees = floor(raw * 360 / full scale) as raw * ceil(2^24 * 360 / full scale) >> 24;
	// exact for every 12-bit raw value and full scale up to 4096
	localparam int SCL_K = 24;
	localparam int RCP_W = 33;
	localparam logic [RCP_W-1:0] ENC_RCP = RCP_W'(((64'd360 << SCL_K) +
		64'(ENCODER_FULL_SCALE) - 64'd1) / 64'(ENCODER_FULL_SCALE));
	localparam logic [RCP_W-1:0] POT_RCP = RCP_W'(((64'd360 << SCL_K) +
		64'(SETPOINT_FULL_SCALE) - 64'd1) / 64'(SETPOINT_FULL_SCALE));

	// input capture
	logic [RAW_W-1:0] enc_q, pot_q;

	// angle scaling
	logic [RAW_W+RCP_W-1:0] enc_prod, pot_prod;
	logic [DVD_W-1:0] enc_full, pot_full;
	logic [ANGLE_W-1:0] enc_deg, pot_deg;

	// divider hookup
	logic [DVD_W-1:0] dvd, quo;
	logic [DSR_W-1:0] dsr;
	logic div_busy, div_done;

	// angle state
	logic [ANGLE_W-1:0] angle_q, prev_q;
	logic signed [TURN_W-1:0] turn_q;
	logic signed [ANGLE_W:0] diff;
	logic signed [ERR_W-1:0] shaft_full;
	logic [SHAFT_W-1:0] shaft_q;

	// window
	logic [ANGLE_W-1:0] win_mem [WINDOW_LEN];
	logic [WINDOW_LEN-1:0] win_vld_q;
	logic [ANGLE_W-1:0] rd_q;
	logic rd_vld_q;
	logic [IDX_W-1:0] idx_q;
	logic [FILL_W-1:0] fill_q;
	logic [SUM_W-1:0] sum_q;
	logic [ANGLE_W-1:0] old_val;

	// PID
	logic [ANGLE_W-1:0] avg_q;
	logic signed [ERR_W-1:0] err_q, e1_q, e2_q;
	logic signed [COEF_W-1:0] mul_a;
	logic signed [ERR_W-1:0] mul_b;
	logic signed [PROD_W-1:0] prod_q;
	logic signed [ACC_W-1:0] acc_q;
	logic signed [DRV_W-1:0] drive_q;
	logic signed [ACC_W-9:0] t_trunc;
	logic signed [DRV_W-1:0] t_sat;
	logic [DRV_W:0] t_abs;

	// output register
	logic out_vld_q;

	assign enc_prod = {{RCP_W{1'b0}}, enc_q} * {{RAW_W{1'b0}}, ENC_RCP};
	assign pot_prod = {{RCP_W{1'b0}}, pot_q} * {{RAW_W{1'b0}}, POT_RCP};
	assign enc_full = enc_prod[SCL_K +: DVD_W];
	assign pot_full = pot_prod[SCL_K +: DVD_W];
	assign enc_deg  = (enc_full > DVD_W'(ANGLE_MAX)) ? ANGLE_MAX : enc_full[ANGLE_W-1:0];
	assign pot_deg  = (pot_full > DVD_W'(ANGLE_MAX)) ? ANGLE_MAX : pot_full[ANGLE_W-1:0];

	// the divider only forms the window average
	assign dvd = DVD_W'(sum_q);
	assign dsr = DSR_W'(fill_q);

	mppl_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.go       (cmd.div_go),
		.dividend (dvd),
		.divisor  (dsr),
		.quotient (quo),
		.busy     (div_busy),
		.done     (div_done)
	);

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			enc_q <= encoder_sample;
			pot_q <= setpoint_sample;
		end
		if (cmd.cap_enc) begin
			angle_q <= enc_deg;
		end
	end

	// unwrap: a rise over half a turn removes a turn, a fall adds one
	assign diff = $signed({1'b0, angle_q}) - $signed({1'b0, prev_q});
	assign shaft_full = ERR_W'(turn_q) * 21'sd360 + $signed({12'd0, angle_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q <= '0;
			turn_q <= '0;
		end else if (cmd.turn_upd) begin
			prev_q <= angle_q;
			if (diff > 10'sd180) begin
				if (turn_q > TURN_LO) begin
					turn_q <= turn_q - 1'b1;
				end
			end else if (diff < -10'sd180) begin
				if (turn_q < TURN_HI) begin
					turn_q <= turn_q + 1'b1;
				end
			end
		end
	end

	// window memory: read the slot about to be replaced, write it when the new value lands
	always_ff @(posedge clk) begin
		if (cmd.turn_upd) begin
			rd_q <= win_mem[idx_q];
		end
		if (cmd.cap_pot) begin
			win_mem[idx_q] <= pot_deg;
		end
		if (cmd.cap_pot) begin
			shaft_q <= shaft_full[ERR_W-1] ? '0 : shaft_full[SHAFT_W-1:0];
		end
	end

	assign old_val = rd_vld_q ? rd_q : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_vld_q <= '0;
			rd_vld_q  <= 1'b0;
			idx_q     <= '0;
			fill_q    <= '0;
			sum_q     <= '0;
		end else begin
			if (cmd.turn_upd) begin
				rd_vld_q <= win_vld_q[idx_q];
			end
			if (cmd.cap_pot) begin
				win_vld_q[idx_q] <= 1'b1;
				sum_q <= sum_q - SUM_W'(old_val) + SUM_W'(pot_deg);
				idx_q <= (idx_q == IDX_W'(WINDOW_LEN - 1)) ? '0 : idx_q + 1'b1;
				if (fill_q != FILL_W'(WINDOW_LEN)) begin
					fill_q <= fill_q + 1'b1;
				end
			end
		end
	end

	// shared multiplier, one product per cycle
	always_comb begin
		case (cmd.mul_sel)
			MUL_NOW: begin
				mul_a = coef_error_now;
				mul_b = err_q;
			end
			MUL_PREV: begin
				mul_a = coef_error_prev;
				mul_b = e1_q;
			end
			MUL_PREV2: begin
				mul_a = coef_error_prev2;
				mul_b = e2_q;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.cap_avg) begin
			avg_q <= quo[ANGLE_W-1:0];
			err_q <= $signed({12'd0, quo[ANGLE_W-1:0]}) - $signed({1'b0, shaft_q});
		end
		if (cmd.mul_go) begin
			prod_q <= mul_a * mul_b;
		end
		if (cmd.acc_init) begin
			acc_q <= {{(ACC_W-DRV_W-8){drive_q[DRV_W-1]}}, drive_q, 8'd0};
		end else if (cmd.acc_add) begin
			acc_q <= acc_q + ACC_W'(prod_q);
		end
	end

	// divide by 256 toward zero, then clamp to 32 bits
	assign t_trunc = (ACC_W-8)'((acc_q >>> 8) + $signed({{(ACC_W-9){1'b0}},
		acc_q[ACC_W-1] && (acc_q[7:0] != 8'd0)}));
	assign t_sat = (t_trunc > (ACC_W-8)'(DRV_MAX)) ? DRV_MAX :
		(t_trunc < (ACC_W-8)'(DRV_MIN)) ? DRV_MIN : t_trunc[DRV_W-1:0];
	assign t_abs = t_sat[DRV_W-1] ? -{t_sat[DRV_W-1], t_sat} : {1'b0, t_sat};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			drive_q   <= '0;
			e1_q      <= '0;
			e2_q      <= '0;
			out_vld_q <= 1'b0;
		end else begin
			if (cmd.finish) begin
				drive_q   <= t_sat;
				e2_q      <= e1_q;
				e1_q      <= err_q;
				out_vld_q <= 1'b1;
			end else if (out_ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			drive_magnitude <= (t_abs > (DRV_W+1)'(16'hFFFF)) ? '1 : t_abs[MAG_W-1:0];
			drive_forward   <= !t_sat[DRV_W-1] && (t_sat != '0);
			shaft_angle     <= shaft_q;
			setpoint_angle  <= avg_q;
		end
	end

	assign out_valid    = out_vld_q;
	assign sts.div_busy = div_busy;
	assign sts.div_done = div_done;
	assign sts.out_free = !out_vld_q || out_ready;
endmodule

// ===== src/mppl_ctrl.sv =====
// Controller: sequences one control tick through the datapath.
module mppl_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  mppl_pkg::sts_t sts,
	output mppl_pkg::cmd_t cmd
);
	import mppl_pkg::*;

	typedef enum logic [10:0] {
		ST_IDLE = 11'b000_0000_0001,
		ST_SENC = 11'b000_0000_0010,
		ST_TURN = 11'b000_0000_0100,
		ST_SPOT = 11'b000_0000_1000,
		ST_DAVG = 11'b000_0001_0000,
		ST_WAVG = 11'b000_0010_0000,
		ST_MUL0 = 11'b000_0100_0000,
		ST_MUL1 = 11'b000_1000_0000,
		ST_MUL2 = 11'b001_0000_0000,
		ST_MACC = 11'b010_0000_0000,
		ST_FIN  = 11'b100_0000_0000
	} state_t;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load_in = 1'b1;
					state_d     = ST_SENC;
				end
			end
			ST_SENC: begin
				cmd.cap_enc = 1'b1;
				state_d     = ST_TURN;
			end
			ST_TURN: begin
				cmd.turn_upd = 1'b1;
				state_d      = ST_SPOT;
			end
			ST_SPOT: begin
				cmd.cap_pot = 1'b1;
				state_d     = ST_DAVG;
			end
			ST_DAVG: begin
				cmd.div_go = 1'b1;
				state_d    = ST_WAVG;
			end
			ST_WAVG: begin
				if (sts.div_done) begin
					cmd.cap_avg = 1'b1;
					state_d     = ST_MUL0;
				end
			end
			ST_MUL0: begin
				cmd.mul_go   = 1'b1;
				cmd.mul_sel  = MUL_NOW;
				cmd.acc_init = 1'b1;
				state_d      = ST_MUL1;
			end
			ST_MUL1: begin
				cmd.mul_go  = 1'b1;
				cmd.mul_sel = MUL_PREV;
				cmd.acc_add = 1'b1;
				state_d     = ST_MUL2;
			end
			ST_MUL2: begin
				cmd.mul_go  = 1'b1;
				cmd.mul_sel = MUL_PREV2;
				cmd.acc_add = 1'b1;
				state_d     = ST_MACC;
			end
			ST_MACC: begin
				cmd.acc_add = 1'b1;
				state_d     = ST_FIN;
			end
			ST_FIN: begin
				// hold until the output register can take the result
				if (sts.out_free) begin
					cmd.finish = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end
endmodule

// ===== src/motor_position_pid_loop_core.sv =====
// Top level of the motor position PID loop: stream ports, register port, controller and datapath.
//
// One input transfer is one control tick: a raw 12-bit encoder reading and a raw 12-bit
// setpoint reading. The encoder reading is scaled to degrees and unwrapped into a multi-turn
// shaft angle (turn count saturates at +/-TURN_LIMIT, angle clamped at zero); the setpoint is
// scaled and smoothed by a WINDOW_LEN-tap moving average that divides by the samples held
// during warm-up. An incremental PID then adds (c0*e + c1*e1 + c2*e2)/256 to a signed 32-bit
// drive accumulator, truncating toward zero and saturating. Each tick yields one output
// transfer with drive magnitude (saturated at 65535), direction and both angles.
// Each item runs in order from its input transfer until the next one can be taken: the
// accept cycle; scaling the encoder reading (reciprocal multiply), updating the turn count
// and storing the scaled setpoint in the window; the average on a radix-2 divider (start,
// one quotient bit per dividend bit, done); products on one shared 24x21 multiplier with
// their accumulation; and a finishing cycle, in which the result lands in the output register.
// The finishing cycle stretches only while an earlier result still waits.
// Items are handled one at a time; a result waiting in the output register does not stop
// the next item from being accepted. The three coefficients must be written over the register
// port only while the block is idle, which it does not enforce; reads are 24-bit, zero-extended.
`include "motor_position_pid_loop_core_defines.svh"
module motor_position_pid_loop_core #(
	parameter int WINDOW_LEN          = 20,
	parameter int ENCODER_FULL_SCALE  = 4088,
	parameter int SETPOINT_FULL_SCALE = 4096,
	parameter int TURN_LIMIT          = 2047
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// input stream
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [23:0]                   s_tdata,  // [11:0] encoder_sample, [23:12] setpoint_sample
	// output stream
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [47:0]                   m_tdata,  // [15:0] drive_magnitude, [16] drive_forward,
	                                                 // [36:17] shaft_angle, [45:37] setpoint_angle
	// register port
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [mppl_pkg::ADDR_W-1:0]   paddr,
	input  logic [31:0]                   pwdata,
	output logic [31:0]                   prdata,
	output logic                          pready
);
	import mppl_pkg::*;

	cmd_t cmd;
	sts_t sts;

	logic signed [COEF_W-1:0] coef_now_q, coef_prev_q, coef_prev2_q;
	logic cfg_wr;

	logic [MAG_W-1:0]   drive_magnitude;
	logic               drive_forward;
	logic [SHAFT_W-1:0] shaft_angle;
	logic [ANGLE_W-1:0] setpoint_angle;

	// register port: zero wait states, write lands on the access cycle
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_now_q   <= 24'sd922573;
			coef_prev_q  <= -24'sd1780502;
			coef_prev2_q <= 24'sd858240;
		end else if (cfg_wr) begin
			case (paddr[3:2])
				REG_COEF_NOW:   coef_now_q   <= pwdata[COEF_W-1:0];
				REG_COEF_PREV:  coef_prev_q  <= pwdata[COEF_W-1:0];
				REG_COEF_PREV2: coef_prev2_q <= pwdata[COEF_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			REG_COEF_NOW:   prdata = {8'd0, coef_now_q};
			REG_COEF_PREV:  prdata = {8'd0, coef_prev_q};
			REG_COEF_PREV2: prdata = {8'd0, coef_prev2_q};
			default:        prdata = '0;
		endcase
	end

	mppl_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	mppl_datapath #(
		.WINDOW_LEN          (WINDOW_LEN),
		.ENCODER_FULL_SCALE  (ENCODER_FULL_SCALE),
		.SETPOINT_FULL_SCALE (SETPOINT_FULL_SCALE),
		.TURN_LIMIT          (TURN_LIMIT)
	) u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.sts              (sts),
		.encoder_sample   (s_tdata[11:0]),
		.setpoint_sample  (s_tdata[23:12]),
		.coef_error_now   (coef_now_q),
		.coef_error_prev  (coef_prev_q),
		.coef_error_prev2 (coef_prev2_q),
		.out_valid        (m_tvalid),
		.out_ready        (m_tready),
		.drive_magnitude  (drive_magnitude),
		.drive_forward    (drive_forward),
		.shaft_angle      (shaft_angle),
		.setpoint_angle   (setpoint_angle)
	);

	assign m_tdata = {2'b00, setpoint_angle, shaft_angle, drive_forward, drive_magnitude};

	// an accepted tick keeps the input closed while it is worked on
	`MPPL_ASSERT_NXT(a_in_closes, s_tvalid && s_tready, !s_tready, "input open after transfer")
	// the divider never runs while the block waits for a new tick
	`MPPL_ASSERT_IMP(a_div_idle, sts.div_busy, !s_tready, "divider busy while idle")
	// forward drive always carries a nonzero magnitude
	`MPPL_ASSERT_IMP(a_fwd_mag, m_tvalid && m_tdata[16], m_tdata[15:0] != 16'd0,
		"forward drive with zero magnitude")
endmodule

// ===== sim/tb_motor_position_pid_loop_core.sv =====
// Self-checking testbench for the motor position PID loop core.
`timescale 1ns / 100ps
module tb_motor_position_pid_loop_core;
	import mppl_pkg::*;

	localparam int WINDOW_LEN          = 20;
	localparam int ENCODER_FULL_SCALE  = 4088;
	localparam int SETPOINT_FULL_SCALE = 4096;
	localparam int TURN_LIMIT          = 2047;
	localparam int RANDOM_TICKS        = 500;
	localparam int IDLE_LIMIT          = 20000;
	// leave margin before register writes and at the end
	localparam int SETTLE_CYCLES       = 200;

	typedef struct packed {
		logic [8:0]  setpoint_angle;
		logic [19:0] shaft_angle;
		logic        drive_forward;
		logic [15:0] drive_magnitude;
	} drive_result_t;

	typedef struct {
		logic [11:0] enc;
		logic [11:0] pot;
		logic        has_known;
		logic [15:0] k_mag;
		logic        k_fwd;
		logic [19:0] k_shaft;
		logic [8:0]  k_sp;
	} tick_row_t;

	logic clk;
	logic arst_n;
	logic s_tvalid;
	logic s_tready;
	logic [23:0] s_tdata;
	logic m_tvalid;
	logic m_tready;
	logic [47:0] m_tdata;
	logic psel;
	logic penable;
	logic pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic pready;

	motor_position_pid_loop_core #(
		.WINDOW_LEN(WINDOW_LEN),
		.ENCODER_FULL_SCALE(ENCODER_FULL_SCALE),
		.SETPOINT_FULL_SCALE(SETPOINT_FULL_SCALE),
		.TURN_LIMIT(TURN_LIMIT)
	) u_top (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	// Predictor state: mirror of the loop's registers
	int          gain_now, gain_prev, gain_prev2;
	int          last_angle;
	int          turns;
	int          taps [WINDOW_LEN];
	int          tap_sum, tap_pos, tap_count;
	longint      err_1, err_2;
	longint      drive_acc;

	drive_result_t expected_drive [$];
	int  mismatch_count;
	int  results_seen;
	int  idle_cycles;
	logic rx_stall_mode;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	task automatic report(input string what, input longint got, input longint want);
		$display("mismatch at result %0d: %s got %0d expected %0d",
			results_seen, what, got, want);
		mismatch_count++;
	endtask

	function automatic int to_degrees(input logic [11:0] raw, input int full);
		int d;
		d = int'(raw) * 360 / full;
		return d > 511 ? 511 : d;
	endfunction

	function automatic longint sign24(input logic [23:0] v);
		return longint'($signed(v));
	endfunction

	task automatic reset_model();
		gain_now = 922573;
		gain_prev = -1780502;
		gain_prev2 = 858240;
		last_angle = 0;
		turns = 0;
		foreach (taps[i]) taps[i] = 0;
		tap_sum = 0;
		tap_pos = 0;
		tap_count = 0;
		err_1 = 0;
		err_2 = 0;
		drive_acc = 0;
	endtask

	// Advance the predicted loop by one tick and queue the expected transfer
	task automatic predict_tick(input logic [11:0] enc, input logic [11:0] pot);
		int angle, pot_deg, diff, shaft, avg;
		longint err, t, mag;
		drive_result_t r;
		angle = to_degrees(enc, ENCODER_FULL_SCALE);
		pot_deg = to_degrees(pot, SETPOINT_FULL_SCALE);
		diff = angle - last_angle;
		if (diff > 180) begin
			if (turns > -TURN_LIMIT) turns--;
		end else if (diff < -180) begin
			if (turns < TURN_LIMIT) turns++;
		end
		shaft = turns * 360 + angle;
		if (shaft < 0) shaft = 0;
		tap_sum = tap_sum - taps[tap_pos] + pot_deg;
		taps[tap_pos] = pot_deg;
		tap_pos = (tap_pos + 1) % WINDOW_LEN;
		if (tap_count < WINDOW_LEN) tap_count++;
		avg = tap_sum / tap_count;
		err = avg - shaft;
		t = drive_acc * 256 + gain_now * err + gain_prev * err_1 + gain_prev2 * err_2;
		t = t / 256; // truncates toward zero
		if (t > 64'sd2147483647) t = 64'sd2147483647;
		if (t < -64'sd2147483648) t = -64'sd2147483648;
		drive_acc = t;
		err_2 = err_1;
		err_1 = err;
		last_angle = angle;
		mag = t < 0 ? -t : t;
		if (mag > 65535) mag = 65535;
		r.drive_magnitude = mag[15:0];
		r.drive_forward = t > 0;
		r.shaft_angle = shaft[19:0];
		r.setpoint_angle = avg[8:0];
		expected_drive.push_back(r);
	endtask

	// Receiver: stall on its own pattern, check each transfer against the oldest expectation
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				drive_result_t got, want;
				got = drive_result_t'(m_tdata[45:0]);
				if (m_tdata[47:46] !== 2'b00)
					report("pad bits", m_tdata[47:46], 0);
				if (expected_drive.size() == 0) begin
					$display("unexpected output transfer %0d", results_seen);
					mismatch_count++;
				end else begin
					want = expected_drive.pop_front();
					if (got.drive_magnitude !== want.drive_magnitude)
						report("drive_magnitude", got.drive_magnitude, want.drive_magnitude);
					if (got.drive_forward !== want.drive_forward)
						report("drive_forward", got.drive_forward, want.drive_forward);
					if (got.shaft_angle !== want.shaft_angle)
						report("shaft_angle", got.shaft_angle, want.shaft_angle);
					if (got.setpoint_angle !== want.setpoint_angle)
						report("setpoint_angle", got.setpoint_angle, want.setpoint_angle);
				end
				results_seen++;
			end
			if ($urandom_range(0, 63) == 0) rx_stall_mode <= ~rx_stall_mode;
			m_tready <= rx_stall_mode ? ($urandom_range(0, 3) == 0) : 1'b1;
		end
	end

	// Watchdog: count cycles with no transfer on either stream
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	task automatic write_gain(input logic [1:0] idx, input int value);
		@(posedge clk);
		psel <= 1'b1;
		pwrite <= 1'b1;
		penable <= 1'b0;
		paddr <= ADDR_W'(idx * 4);
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			REG_COEF_NOW:   gain_now = int'(sign24(value[23:0]));
			REG_COEF_PREV:  gain_prev = int'(sign24(value[23:0]));
			REG_COEF_PREV2: gain_prev2 = int'(sign24(value[23:0]));
			default: ;
		endcase
	endtask

	task automatic set_gains(input int g0, input int g1, input int g2);
		write_gain(REG_COEF_NOW, g0);
		write_gain(REG_COEF_PREV, g1);
		write_gain(REG_COEF_PREV2, g2);
	endtask

	// Hand one tick to the block; hold tvalid until the transfer happens
	task automatic send_tick(input logic [11:0] enc, input logic [11:0] pot);
		s_tvalid <= 1'b1;
		s_tdata <= {pot, enc};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		predict_tick(enc, pot);
	endtask

	task automatic drop_valid();
		s_tvalid <= 1'b0;
	endtask

	// Wait for every expected transfer, then let the pipeline settle
	task automatic drain();
		drop_valid();
		while (expected_drive.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Send a run of ticks in random bursts with random gaps
	task automatic random_ticks(input int count, input int style);
		int burst;
		int gap;
		logic [11:0] enc, pot;
		int base;
		burst = 0;
		base = $urandom_range(0, 4095);
		for (int i = 0; i < count; i++) begin
			if (burst == 0) begin
				gap = $urandom_range(0, 6) * $urandom_range(0, 30);
				if (gap != 0) begin
					drop_valid();
					repeat (gap) @(posedge clk);
				end
				burst = $urandom_range(1, 12);
			end
			burst--;
			case (style)
				0: begin // smooth rotation with random direction and speed, wraps across zero
					base = (base + $urandom_range(0, 400) - 200 + 4096) % 4096;
					enc = base[11:0];
				end
				1: enc = 12'($urandom_range(0, 4095));
				default: begin // fast spin in one direction to push the turn counter hard
					base = (base + 1500) % 4096;
					enc = base[11:0];
				end
			endcase
			pot = ($urandom_range(0, 3) == 0) ? 12'($urandom) : 12'($urandom_range(0, 4095) ^ 12'hfff);
			send_tick(enc, pot);
		end
		drain();
	endtask

	tick_row_t tick_table [$];
	int gain_sets [6][3];

	initial begin
		tick_row_t row;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		m_tready = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		mismatch_count = 0;
		results_seen = 0;
		idle_cycles = 0;
		rx_stall_mode = 1'b0;
		reset_model();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed table: known rows come straight from reset with zero gains
		//   enc, pot, known, mag, fwd, shaft, setpoint
		tick_table.push_back('{12'd0,    12'd0,    1, 16'd0, 1'b0, 20'd0,   9'd0});
		tick_table.push_back('{12'd4095, 12'd4095, 1, 16'd0, 1'b0, 20'd0,   9'd179});
		tick_table.push_back('{12'd0,    12'd0,    1, 16'd0, 1'b0, 20'd0,   9'd119});
		tick_table.push_back('{12'd2044, 12'd2048, 0, 0, 0, 0, 0});
		tick_table.push_back('{12'd4087, 12'd4095, 0, 0, 0, 0, 0});
		tick_table.push_back('{12'd4088, 12'd1,    0, 0, 0, 0, 0});
		tick_table.push_back('{12'd10,   12'd2730, 0, 0, 0, 0, 0});
		tick_table.push_back('{12'd3000, 12'd1365, 0, 0, 0, 0, 0});
		tick_table.push_back('{12'd1000, 12'd0,    0, 0, 0, 0, 0});
		tick_table.push_back('{12'd2500, 12'd4095, 0, 0, 0, 0, 0});
		tick_table.push_back('{12'd4000, 12'hAAA,  0, 0, 0, 0, 0});
		tick_table.push_back('{12'd100,  12'h555,  0, 0, 0, 0, 0});

		// Zero gains for the known rows: drive stays at zero
		set_gains(0, 0, 0);
		for (int i = 0; i < 3; i++) begin
			row = tick_table[i];
			send_tick(row.enc, row.pot);
			if (row.has_known) begin
				// replace the prediction with the hand-written value
				void'(expected_drive.pop_back());
				expected_drive.push_back({row.k_sp, row.k_shaft, row.k_fwd, row.k_mag});
			end
		end
		drain();

		// Remaining rows with default-like gains, then extreme gains to saturate the drive
		set_gains(922573, -1780502, 858240);
		for (int i = 3; i < tick_table.size(); i++) begin
			row = tick_table[i];
			send_tick(row.enc, row.pot);
		end
		drain();
		set_gains(24'h7fffff, 24'h800000, 24'h7fffff);
		for (int i = 3; i < tick_table.size(); i++) begin
			row = tick_table[i];
			send_tick(row.enc, row.pot);
		end
		drain();

		// Random part: several gain settings, extremes among them
		gain_sets = '{
			'{922573, -1780502, 858240},
			'{8388607, 8388607, 8388607},
			'{-8388608, -8388608, -8388608},
			'{256, 0, 0},
			'{-300, 100, -50},
			'{0, 0, 0}};
		for (int p = 0; p < 6; p++) begin
			set_gains(gain_sets[p][0], gain_sets[p][1], gain_sets[p][2]);
			random_ticks(RANDOM_TICKS / 12, 0);
			random_ticks(RANDOM_TICKS / 24, 1);
			random_ticks(RANDOM_TICKS / 24, 2);
		end
		// Random gains with full-range bits
		for (int p = 0; p < 2; p++) begin
			set_gains($urandom, $urandom, $urandom);
			random_ticks(RANDOM_TICKS / 12, p);
		end

		$display("covered %0d output transfers over directed extremes, wrap-around,", results_seen);
		$display("multi-turn counting and eight gain settings under random stalls");
		if (mismatch_count == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end
endmodule

// ===== motor_position_pid_loop_core.f =====
+incdir+src
src/mppl_pkg.sv
src/mppl_div.sv
src/mppl_datapath.sv
src/mppl_ctrl.sv
src/motor_position_pid_loop_core.sv
sim/tb_motor_position_pid_loop_core.sv
